// ===== sv/prf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prf_pkg
// Shared types, sizes and byte arithmetic of the adaptive PNG row filter.
// ----------------------------------------------------------------------------
package prf_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int CFG_W       = 12;
    localparam int PIX_W       = 32;
    localparam int SCORE_W     = 21;
    localparam int COST_W      = 10;
    localparam int NUM_FILT    = 5;
    localparam int NUM_SLOTS   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    typedef enum logic [1:0] {
        SLOT0 = 2'd0,
        SLOT1 = 2'd1,
        SLOT2 = 2'd2
    } slot_t;

    // per-word control decided at the front
    typedef struct packed {
        logic drain;        // drain word, pixel bytes meaningless
        logic emit;         // a pixel of the previous row goes out
        logic row_first;
        logic row_last;
        logic image_final;
        logic restart;      // back to start-of-image state afterwards
    } prf_ctl_t;

    typedef struct packed {
        prf_ctl_t           ctl;
        logic [PIX_W-1:0]   px;    // incoming pixel
        logic [PIX_W-1:0]   up;    // previous row, same column (zero on first row)
        logic [PIX_W-1:0]   old;   // row before that, same column (or zero)
    } prf_item_t;

    function automatic slot_t slot_next(slot_t s);
        slot_t r;
        unique case (s)
            SLOT0:   r = SLOT1;
            SLOT1:   r = SLOT2;
            default: r = SLOT0;
        endcase
        return r;
    endfunction

    function automatic slot_t slot_prev(slot_t s);
        slot_t r;
        unique case (s)
            SLOT0:   r = SLOT2;
            SLOT1:   r = SLOT0;
            default: r = SLOT1;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] paeth_byte(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dc;
        logic [8:0]        pa;
        logic [8:0]        pb;
        logic [8:0]        pc;
        logic [7:0]        r;
        da = $signed({2'b00, b}) - $signed({2'b00, c});
        db = $signed({2'b00, a}) - $signed({2'b00, c});
        dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
        pa = da[9] ? 9'(-da) : da[8:0];
        pb = db[9] ? 9'(-db) : db[8:0];
        pc = dc[9] ? 9'(-dc) : dc[8:0];
        if (pa <= pb && pa <= pc)
            r = a;
        else if (pb <= pc)
            r = b;
        else
            r = c;
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] filter_pix(filt_t t, logic [PIX_W-1:0] x,
                                                    logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                                    logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] res;
        logic [7:0]       pred;
        logic [8:0]       sum;
        res = '0;
        for (int k = 0; k < 4; k++)
        begin
            sum = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
            unique case (t)
                FILT_SUB:   pred = a[8*k +: 8];
                FILT_UP:    pred = b[8*k +: 8];
                FILT_AVG:   pred = sum[8:1];
                FILT_PAETH: pred = paeth_byte(a[8*k +: 8], b[8*k +: 8], c[8*k +: 8]);
                default:    pred = 8'd0;
            endcase
            res[8*k +: 8] = x[8*k +: 8] - pred;
        end
        return res;
    endfunction

    // signed magnitude of each residual byte, summed
    function automatic logic [COST_W-1:0] pixel_cost(logic [PIX_W-1:0] px);
        logic [COST_W-1:0] s;
        logic [7:0]        v;
        s = '0;
        for (int k = 0; k < 4; k++)
        begin
            v = px[8*k +: 8];
            s = s + COST_W'(v[7] ? 8'(-v) : v);
        end
        return s;
    endfunction

endpackage

// ===== sv/prf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/prf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prf_front
// Input side: accepts words, tracks column, row count and line rotation,
// writes and reads the three-row line store and pushes classified words.
// ----------------------------------------------------------------------------
module prf_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [prf_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [prf_pkg::PIX_W-1:0]        s_axis_tdata,
    input  logic                             s_axis_tuser,
    input  logic [prf_pkg::QCNT_W-1:0]       q_count,
    output logic                             push_valid,
    output prf_pkg::prf_item_t               push_item
);

    logic [prf_pkg::CFG_W-1:0] width_reg;
    logic [prf_pkg::COL_W-1:0] col_reg, col_next;
    logic [1:0]                rows_reg, rows_next;
    prf_pkg::slot_t            rot_reg, rot_next;
    logic                      pend_reg;
    prf_pkg::prf_ctl_t         ctl_reg, ctl_next;
    logic [prf_pkg::PIX_W-1:0] px_reg;
    prf_pkg::slot_t            cur_reg;
    logic                      useb_reg, useb_next;

    logic [prf_pkg::CFG_W-1:0] w_eff;
    logic                      last;
    logic                      accept;
    logic                      drain;
    logic [prf_pkg::QCNT_W:0]  used;
    logic [prf_pkg::PIX_W-1:0] rd_data [prf_pkg::NUM_SLOTS];
    logic [prf_pkg::PIX_W-1:0] up_raw, old_raw;

    assign used          = {1'b0, q_count} + (prf_pkg::QCNT_W+1)'(pend_reg);
    assign s_axis_tready = used < (prf_pkg::QCNT_W+1)'(prf_pkg::QUEUE_DEPTH);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign drain         = s_axis_tuser;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = prf_pkg::CFG_W'(1);
        else if (width_reg > prf_pkg::CFG_W'(prf_pkg::MAX_WIDTH))
            w_eff = prf_pkg::CFG_W'(prf_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;
    end

    assign last = ({1'b0, col_reg} + prf_pkg::CFG_W'(1)) >= w_eff;

    always_comb
    begin
        col_next  = col_reg;
        rows_next = rows_reg;
        rot_next  = rot_reg;
        useb_next = rows_reg >= 2'd2;
        ctl_next.drain       = drain;
        ctl_next.emit        = rows_reg != 2'd0;
        ctl_next.row_first   = col_reg == '0;
        ctl_next.row_last    = last;
        ctl_next.image_final = drain && last && rows_reg != 2'd0;
        ctl_next.restart     = drain && (last || rows_reg == 2'd0);
        if (ctl_next.restart)
        begin
            col_next  = '0;
            rows_next = 2'd0;
            rot_next  = prf_pkg::SLOT0;
        end
        else if (!last)
            col_next = col_reg + prf_pkg::COL_W'(1);
        else
        begin
            col_next = '0;
            if (rows_reg != 2'd2)
                rows_next = rows_reg + 2'd1;
            rot_next = prf_pkg::slot_next(rot_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= prf_pkg::CFG_W'(1);
            col_reg   <= '0;
            rows_reg  <= 2'd0;
            rot_reg   <= prf_pkg::SLOT0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                width_reg <= cfg_wr_data;
            pend_reg <= accept;
            if (accept)
            begin
                col_reg  <= col_next;
                rows_reg <= rows_next;
                rot_reg  <= rot_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl_reg  <= ctl_next;
            px_reg   <= s_axis_tdata;
            cur_reg  <= rot_reg;
            useb_reg <= useb_next;
        end
    end

    for (genvar i = 0; i < prf_pkg::NUM_SLOTS; i++)
    begin : g_bank
        prf_ram #(
            .WIDTH (prf_pkg::PIX_W),
            .DEPTH (prf_pkg::MAX_WIDTH)
        ) u_bank (
            .clk     (clk),
            .wr_en   (accept && !drain && rot_reg == prf_pkg::slot_t'(i)),
            .wr_addr (col_reg),
            .wr_data (s_axis_tdata),
            .rd_addr (col_reg),
            .rd_data (rd_data[i])
        );
    end

    always_comb
    begin
        unique case (prf_pkg::slot_prev(cur_reg))
            prf_pkg::SLOT0: up_raw = rd_data[0];
            prf_pkg::SLOT1: up_raw = rd_data[1];
            default:        up_raw = rd_data[2];
        endcase
        unique case (prf_pkg::slot_next(cur_reg))
            prf_pkg::SLOT0: old_raw = rd_data[0];
            prf_pkg::SLOT1: old_raw = rd_data[1];
            default:        old_raw = rd_data[2];
        endcase
    end

    assign push_valid    = pend_reg;
    assign push_item.ctl = ctl_reg;
    assign push_item.px  = px_reg;
    assign push_item.up  = ctl_reg.emit ? up_raw : '0;
    assign push_item.old = useb_reg ? old_raw : '0;

endmodule

// ===== sv/prf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prf_queue
// Short FIFO between the classifying front and the filtering back.
// ----------------------------------------------------------------------------
module prf_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push_valid,
    input  prf_pkg::prf_item_t           push_item,
    input  logic                         pop,
    output logic                         pop_valid,
    output prf_pkg::prf_item_t           pop_item,
    output logic [prf_pkg::QCNT_W-1:0]   count
);

    prf_pkg::prf_item_t         mem_reg [prf_pkg::QUEUE_DEPTH];
    logic [prf_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [prf_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic                       do_pop;

    assign pop_valid = cnt_reg != '0;
    assign do_pop    = pop && pop_valid;
    assign pop_item  = mem_reg[rd_ptr_reg];
    assign count     = cnt_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push_valid && !do_pop)
            cnt_next = cnt_reg + prf_pkg::QCNT_W'(1);
        else if (!push_valid && do_pop)
            cnt_next = cnt_reg - prf_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push_valid)
                wr_ptr_reg <= wr_ptr_reg + prf_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + prf_pkg::QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== sv/prf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prf_back
// Filtering side: residuals under all five filters, pixel costs, running
// scores with row-end choice, and the output register.
// ----------------------------------------------------------------------------
module prf_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  prf_pkg::prf_item_t           q_item,
    output logic                         q_pop,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [prf_pkg::PIX_W-1:0]    m_axis_tdata,  // out0, out1, out2, out3
    output logic [5:0]                   m_axis_tuser,  // out_valid, filter_type[2:0],
                                                        // row_first, image_final
    output logic                         m_axis_tlast   // row_final
);

    logic en;

    // stage 1: residuals
    logic                      s1_vld_reg;
    prf_pkg::prf_ctl_t         s1_ctl_reg;
    logic [prf_pkg::PIX_W-1:0] s1_pix_reg  [prf_pkg::NUM_FILT];
    logic [prf_pkg::PIX_W-1:0] s1_emit_reg [prf_pkg::NUM_FILT];
    logic [prf_pkg::PIX_W-1:0] left_reg, up_left_reg, eleft_reg, eup_left_reg;

    // stage 2: costs
    logic                       s2_vld_reg;
    prf_pkg::prf_ctl_t          s2_ctl_reg;
    logic [prf_pkg::COST_W-1:0] s2_cost_reg [prf_pkg::NUM_FILT];
    logic [prf_pkg::PIX_W-1:0]  s2_emit_reg [prf_pkg::NUM_FILT];

    // stage 3: scores and output
    logic [prf_pkg::SCORE_W-1:0] score_reg  [prf_pkg::NUM_FILT];
    logic [prf_pkg::SCORE_W-1:0] score_next [prf_pkg::NUM_FILT];
    prf_pkg::filt_t              emit_filter_reg;
    prf_pkg::filt_t              best;
    logic [prf_pkg::PIX_W-1:0]   emit_sel;

    logic                      out_vld_reg;
    logic [prf_pkg::PIX_W-1:0] out_data_reg;
    logic [5:0]                out_user_reg;
    logic                      out_last_reg;

    assign en    = !out_vld_reg || m_axis_tready;
    assign q_pop = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg      <= 1'b0;
            s2_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            left_reg        <= '0;
            up_left_reg     <= '0;
            eleft_reg       <= '0;
            eup_left_reg    <= '0;
            emit_filter_reg <= prf_pkg::FILT_NONE;
            for (int t = 0; t < prf_pkg::NUM_FILT; t++)
                score_reg[t] <= '0;
        end
        else if (en)
        begin
            s1_vld_reg  <= q_valid;
            s2_vld_reg  <= s1_vld_reg;
            out_vld_reg <= s2_vld_reg;
            if (q_valid)
            begin
                if (q_item.ctl.row_last || q_item.ctl.restart)
                begin
                    left_reg     <= '0;
                    up_left_reg  <= '0;
                    eleft_reg    <= '0;
                    eup_left_reg <= '0;
                end
                else
                begin
                    left_reg    <= q_item.ctl.drain ? '0 : q_item.px;
                    up_left_reg <= q_item.ctl.drain ? '0 : q_item.up;
                    if (q_item.ctl.emit)
                    begin
                        eleft_reg    <= q_item.up;
                        eup_left_reg <= q_item.old;
                    end
                end
            end
            if (s2_vld_reg)
            begin
                // best at non-drain row end; scores zeroed at row end or drain
                for (int t = 0; t < prf_pkg::NUM_FILT; t++)
                    score_reg[t] <= (s2_ctl_reg.drain || s2_ctl_reg.row_last) ? '0
                                                                             : score_next[t];
                if (s2_ctl_reg.restart)
                    emit_filter_reg <= prf_pkg::FILT_NONE;
                else if (s2_ctl_reg.row_last && !s2_ctl_reg.drain)
                    emit_filter_reg <= best;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ctl_reg <= q_item.ctl;
            for (int t = 0; t < prf_pkg::NUM_FILT; t++)
            begin
                s1_pix_reg[t]  <= prf_pkg::filter_pix(prf_pkg::filt_t'(t), q_item.px,
                                                      left_reg, q_item.up, up_left_reg);
                s1_emit_reg[t] <= prf_pkg::filter_pix(prf_pkg::filt_t'(t), q_item.up,
                                                      eleft_reg, q_item.old, eup_left_reg);
            end
            s2_ctl_reg <= s1_ctl_reg;
            for (int t = 0; t < prf_pkg::NUM_FILT; t++)
            begin
                s2_cost_reg[t] <= prf_pkg::pixel_cost(s1_pix_reg[t]);
                s2_emit_reg[t] <= s1_emit_reg[t];
            end
            if (s2_ctl_reg.emit)
            begin
                out_data_reg <= emit_sel;
                out_user_reg <= {s2_ctl_reg.image_final, s2_ctl_reg.row_first,
                                 emit_filter_reg, 1'b1};
                out_last_reg <= s2_ctl_reg.row_last;
            end
            else
            begin
                out_data_reg <= '0;
                out_user_reg <= '0;
                out_last_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int t = 0; t < prf_pkg::NUM_FILT; t++)
            score_next[t] = s2_ctl_reg.drain ? score_reg[t]
                          : score_reg[t] + prf_pkg::SCORE_W'(s2_cost_reg[t]);
        // strict compare keeps the lower type on a tie
        best = prf_pkg::FILT_NONE;
        for (int t = 1; t < prf_pkg::NUM_FILT; t++)
            if (score_next[t] < score_next[best])
                best = prf_pkg::filt_t'(t);
    end

    always_comb
    begin
        unique case (emit_filter_reg)
            prf_pkg::FILT_SUB:   emit_sel = s2_emit_reg[1];
            prf_pkg::FILT_UP:    emit_sel = s2_emit_reg[2];
            prf_pkg::FILT_AVG:   emit_sel = s2_emit_reg[3];
            prf_pkg::FILT_PAETH: emit_sel = s2_emit_reg[4];
            default:             emit_sel = s2_emit_reg[0];
        endcase
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== sv/png_adaptive_row_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_adaptive_row_filter_top
// Adaptive PNG row filter for RGBA8 with minimum sum of absolute residuals.
// ----------------------------------------------------------------------------
// Every input word (pixel or drain) yields one output word, one row late, at
// one word per clock while m_axis_tready does not hold the output; the output
// word passes the line store read, queue, residuals, and costs with score and
// select before it is offered.
// The rate is set by the score update and the one write and three
// reads per cycle on the three-bank line store of MAX_WIDTH pixels per row.
// ----------------------------------------------------------------------------
module png_adaptive_row_filter_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [prf_pkg::CFG_W-1:0]     cfg_wr_data,   // width_pixels
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [prf_pkg::PIX_W-1:0]     s_axis_tdata,  // chan0, chan1, chan2, chan3
    input  logic                          s_axis_tuser,  // action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [prf_pkg::PIX_W-1:0]     m_axis_tdata,  // out0, out1, out2, out3
    output logic [5:0]                    m_axis_tuser,  // out_valid, filter_type[2:0],
                                                         // row_first, image_final
    output logic                          m_axis_tlast   // row_final
);

    logic                       push_valid;
    prf_pkg::prf_item_t         push_item;
    logic                       q_pop;
    logic                       q_valid;
    prf_pkg::prf_item_t         q_item;
    logic [prf_pkg::QCNT_W-1:0] q_count;

    prf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_count       (q_count),
        .push_valid    (push_valid),
        .push_item     (push_item)
    );

    prf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (q_item),
        .count      (q_count)
    );

    prf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= prf_pkg::QCNT_W'(prf_pkg::QUEUE_DEPTH))
        else $error("line queue over capacity");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && !q_pop |-> q_count < prf_pkg::QCNT_W'(prf_pkg::QUEUE_DEPTH))
        else $error("push into full queue");

    a_empty_word_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0 && m_axis_tuser == '0
                                              && !m_axis_tlast)
        else $error("word without pixel carries data");

    a_filter_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[3:1] <= 3'd4)
        else $error("filter type out of range");
`endif

endmodule
